@@ sv/spc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package spc_pkg;

    localparam int VALUE_W = 11;
    localparam int NEXT_W  = VALUE_W + 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_PUSH,
        S_REPORT
    } state_t;

    typedef struct packed {
        logic load_item;
        logic do_push;
        logic do_pop;
        logic set_fail;
        logic take_value;
        logic clear;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic fail_cond;
        logic next_eq_v;
        logic next_lt_v;
        logic empty;
        logic match;
        logic push_last;
        logic last;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

@@ sv/spc_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module spc_ram #(
    parameter int WIDTH = 11,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

@@ sv/spc_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module spc_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_stall,
    input  wire spc_pkg::status_t status,
    output spc_pkg::cmd_t        cmd
);

    import spc_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                priority if (!status.fail_cond && status.next_lt_v)
                begin
                    state_next = S_PUSH;
                end
                else if (status.last)
                begin
                    state_next = S_REPORT;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_PUSH:
            begin
                if (status.push_last)
                begin
                    state_next = S_EVAL;
                end
            end
            S_REPORT:
            begin
                if (status.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                in_stall      = 1'b0;
                cmd.load_item = in_valid;
            end
            S_EVAL:
            begin
                priority if (status.fail_cond)
                begin
                    cmd.set_fail = 1'b1;
                end
                else if (status.next_eq_v)
                begin
                    cmd.take_value = 1'b1;
                end
                else if (status.next_lt_v)
                begin
                    cmd = '0;
                end
                else if (status.empty || !status.match)
                begin
                    cmd.set_fail = 1'b1;
                end
                else
                begin
                    cmd.do_pop = 1'b1;
                end
            end
            S_PUSH:
            begin
                cmd.do_push = 1'b1;
            end
            S_REPORT:
            begin
                cmd.out_load = status.out_free;
                cmd.clear    = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ sv/spc_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none

module spc_datapath #(
    parameter int MAX_VALUE = 1024
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic [spc_pkg::VALUE_W-1:0]     value,
    input  wire logic                            is_last,
    input  wire logic                            out_stall,
    input  wire spc_pkg::cmd_t                   cmd,
    output spc_pkg::status_t                     status,
    output logic                                 out_valid,
    output logic                                 valid_res
);

    import spc_pkg::*;

    localparam int          DW    = $clog2(MAX_VALUE + 1);
    localparam int          AW    = $clog2(MAX_VALUE);
    localparam logic [31:0] MAX_U = 32'(MAX_VALUE);

    logic [VALUE_W-1:0] value_reg;
    logic               last_reg;
    logic [DW-1:0]      depth_reg;
    logic [DW-1:0]      depth_next;
    logic [NEXT_W-1:0]  next_reg;
    logic [NEXT_W-1:0]  next_next;
    logic               failed_reg;
    logic               failed_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic               valid_res_reg;

    logic [NEXT_W-1:0]  value_ext;
    logic [DW-1:0]      depth_dec;
    logic [VALUE_W-1:0] top_data;

    assign value_ext = {1'b0, value_reg};
    assign depth_dec = depth_reg - DW'(1);

    spc_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (MAX_VALUE)
    ) u_stack (
        .clk     (clk),
        .wr_en   (cmd.do_push),
        .wr_addr (depth_reg[AW-1:0]),
        .wr_data (next_reg[VALUE_W-1:0]),
        .rd_addr (depth_dec[AW-1:0]),
        .rd_data (top_data)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            value_reg <= value;
            last_reg  <= is_last;
        end
        if (cmd.out_load)
        begin
            valid_res_reg <= ~failed_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg     <= '0;
            next_reg      <= NEXT_W'(1);
            failed_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            depth_reg     <= depth_next;
            next_reg      <= next_next;
            failed_reg    <= failed_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        depth_next  = depth_reg;
        next_next   = next_reg;
        failed_next = failed_reg;
        priority if (cmd.clear)
        begin
            depth_next  = '0;
            next_next   = NEXT_W'(1);
            failed_next = 1'b0;
        end
        else if (cmd.do_push)
        begin
            depth_next = depth_reg + DW'(1);
            next_next  = next_reg + NEXT_W'(1);
        end
        else if (cmd.do_pop)
        begin
            depth_next = depth_dec;
        end
        else if (cmd.take_value)
        begin
            next_next = value_ext + NEXT_W'(1);
        end
        else if (cmd.set_fail)
        begin
            failed_next = 1'b1;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        priority if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        status.fail_cond = failed_reg || ({21'd0, value_reg} > MAX_U);
        status.next_eq_v = (next_reg == value_ext);
        status.next_lt_v = (next_reg < value_ext);
        status.empty     = (depth_reg == '0);
        status.match     = (top_data == value_reg);
        status.push_last = ((next_reg + NEXT_W'(1)) == value_ext);
        status.last      = last_reg;
        status.out_free  = !out_valid_reg || !out_stall;
    end

    assign out_valid = out_valid_reg;
    assign valid_res = valid_res_reg;

endmodule

`default_nettype wire

@@ sv/stack_pop_sequence_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Checks that a stream of numbers is a legal pop order for pushes 1, 2, 3, ...
// onto a stack; one result (valid_res = 1 if legal) is sent after the item
// flagged is_last, and the block then starts a fresh sequence. Failure is
// sticky within a sequence; a value above MAX_VALUE or zero fails it. An item
// that pops the top, fails, or equals next_to_push is loaded and compared
// once; an item above next_to_push first writes each number from next_to_push
// up to value - 1 into the stack RAM and then makes one more compare pass.
// The last item of a sequence then loads the result register; while an
// earlier result is still stalled it waits there and the input stays stalled.

module stack_pop_sequence_checker #(
    parameter int MAX_VALUE = 1024
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic [spc_pkg::VALUE_W-1:0] value,
    input  wire logic                        is_last,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic                             valid_res
);

    import spc_pkg::*;

    cmd_t    cmd;
    status_t status;

    spc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    spc_datapath #(
        .MAX_VALUE (MAX_VALUE)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .value     (value),
        .is_last   (is_last),
        .out_stall (out_stall),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .valid_res (valid_res)
    );

endmodule

`default_nettype wire

@@ sv/spc_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module spc_checker (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        in_valid,
    input wire logic                        in_stall,
    input wire logic [spc_pkg::VALUE_W-1:0] value,
    input wire logic                        is_last,
    input wire logic                        out_valid,
    input wire logic                        out_stall,
    input wire logic                        valid_res
);

    // held result transfer keeps its data
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(valid_res))
        else $error("stalled result changed");

    // one item at a time: busy right after a transfer in
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken while item in progress");

    // a result only appears while an item is in progress
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result without an item in progress");

    // no result in the cycle right after an item is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> !$rose(out_valid))
        else $error("result too early");

endmodule

bind stack_pop_sequence_checker spc_checker u_spc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .value     (value),
    .is_last   (is_last),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .valid_res (valid_res)
);

`default_nettype wire

@@ sim/pop_order_monitor.sv @@
`timescale 1ns / 1ps

module pop_order_monitor
    import spc_pkg::*;
#(
    parameter int MAX_VALUE = 1024
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic [VALUE_W-1:0] value,
    input  logic               is_last,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic               valid_res,
    output int                 pending,
    output int                 errors
);

    logic [VALUE_W-1:0] pop_stack [0:MAX_VALUE-1];
    int unsigned        depth;
    int unsigned        next_num;
    bit                 seq_failed;
    logic               verdict_q [$];

    task automatic track_number(input logic [VALUE_W-1:0] v);
        int unsigned vn;
        vn = 32'(v);
        if (seq_failed)
            return;
        if (vn > MAX_VALUE)
        begin
            seq_failed = 1'b1;
            return;
        end
        while (next_num <= vn && depth < MAX_VALUE)
        begin
            pop_stack[depth] = next_num[VALUE_W-1:0];
            depth++;
            next_num++;
        end
        if (depth == 0)
            seq_failed = 1'b1;
        else if (pop_stack[depth-1] == v)
            depth--;
        else
            seq_failed = 1'b1;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        logic exp_res;
        if (!rst_n)
        begin
            depth      = 0;
            next_num   = 1;
            seq_failed = 1'b0;
            verdict_q.delete();
            pending    = 0;
            errors     = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (verdict_q.size() == 0)
                begin
                    $error("unexpected transfer: valid_res actual %0b", valid_res);
                    errors++;
                end
                else
                begin
                    exp_res = verdict_q.pop_front();
                    if (valid_res !== exp_res)
                    begin
                        $error("valid_res mismatch: expected %0b, actual %0b",
                               exp_res, valid_res);
                        errors++;
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                track_number(value);
                if (is_last)
                begin
                    verdict_q.push_back(!seq_failed);
                    depth      = 0;
                    next_num   = 1;
                    seq_failed = 1'b0;
                end
            end
            pending = verdict_q.size();
        end
    end

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
    import spc_pkg::*;

    localparam int MAX_VALUE  = 1024;
    localparam int RAND_ITEMS = 1550;
    localparam int NUM_PHASES = 4;
    localparam int HOLD_LEN   = 400;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [VALUE_W-1:0] value;
    logic               is_last;
    logic               out_valid;
    logic               out_stall;
    logic               valid_res;

    int                 pending;
    int                 errors;
    logic               in_taken;
    int                 idle_pct;
    int                 stall_pct;
    bit                 hold_req = 1'b0;
    int                 hold_cnt = 0;
    int                 sent;
    logic [VALUE_W-1:0] order [$];

    stack_pop_sequence_checker #(.MAX_VALUE(MAX_VALUE)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .value     (value),
        .is_last   (is_last),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .valid_res (valid_res)
    );

    pop_order_monitor #(.MAX_VALUE(MAX_VALUE)) u_monitor (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .value     (value),
        .is_last   (is_last),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .valid_res (valid_res),
        .pending   (pending),
        .errors    (errors)
    );

    initial clk = 1'b0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_taken <= 1'b0;
        else
            in_taken <= in_valid && !in_stall;
    end

    // long receiver hold, counted once requested
    always @(negedge clk)
    begin
        if (hold_req && hold_cnt < HOLD_LEN)
            hold_cnt <= hold_cnt + 1;
    end

    // receiver side; stalls throughout the long hold
    always @(negedge clk)
    begin
        if (hold_req && hold_cnt < HOLD_LEN)
            out_stall <= 1'b1;
        else
            out_stall <= ($urandom_range(99) < stall_pct);
    end

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic push_item(input logic [VALUE_W-1:0] v, input logic l);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        value    <= v;
        is_last  <= l;
        @(negedge clk);
        while (!in_taken)
            @(negedge clk);
    endtask

    task automatic send_sequence();
        for (int i = 0; i < order.size(); i++)
            push_item(order[i], i == order.size() - 1);
        sent += order.size();
    endtask

    // legal pop order of n numbers drawn from pushes 1..m (n <= m)
    task automatic make_pop_order(input int n, input int m);
        int unsigned held [$];
        int unsigned nxt;
        int          k;
        nxt = 1;
        order.delete();
        for (int i = 0; i < n; i++)
        begin
            if (held.size() == 0 || (nxt <= m && $urandom_range(1) == 1))
            begin
                k = ($urandom_range(3) == 0) ? $urandom_range(1, m - nxt + 1) : 1;
                repeat (k)
                begin
                    held.push_back(nxt);
                    nxt++;
                end
            end
            order.push_back(VALUE_W'(held.pop_back()));
        end
    endtask

    task automatic random_sequence(input bit short_only);
        int                 kind;
        int                 n;
        int                 m;
        int                 idx;
        int                 j;
        logic [VALUE_W-1:0] tmp;
        kind = $urandom_range(99);
        n    = short_only ? $urandom_range(1, 3) : $urandom_range(1, 12);
        m    = n + $urandom_range(0, 4);
        if (!short_only && $urandom_range(49) == 0)
            m = $urandom_range(1) ? MAX_VALUE : $urandom_range(n, MAX_VALUE);
        if (kind < 85 || short_only)
        begin
            make_pop_order(n, m);
            if (kind >= 70 && !short_only)
            begin
                idx = $urandom_range(0, n - 1);
                case ($urandom_range(3))
                    0: order[idx] = '0;
                    1: order[idx] = VALUE_W'($urandom_range(MAX_VALUE + 1, 2047));
                    2: order[idx] = VALUE_W'($urandom_range(1, m + 2));
                    default:
                    begin
                        j          = $urandom_range(0, n - 1);
                        tmp        = order[idx];
                        order[idx] = order[j];
                        order[j]   = tmp;
                    end
                endcase
            end
        end
        else
        begin
            order.delete();
            repeat (n)
                order.push_back(VALUE_W'(($urandom_range(3) == 0)
                                         ? $urandom_range(0, 2047)
                                         : $urandom_range(0, m + 1)));
        end
        send_sequence();
    endtask

    initial
    begin
        in_valid  = 1'b0;
        value     = VALUE_W'(1);
        is_last   = 1'b0;
        idle_pct  = 0;
        stall_pct = 0;
        sent      = 0;
        rst_n     = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        order = '{11'd1};           send_sequence();
        order = '{11'd0};           send_sequence();
        order = '{11'd2047};        send_sequence();
        order = '{11'd1025};        send_sequence();
        order = '{11'd1024};        send_sequence();
        order = '{11'd1024, 11'd1025}; send_sequence();
        order = '{11'd1, 11'd2, 11'd3}; send_sequence();
        order = '{11'd3, 11'd1, 11'd2}; send_sequence();
        order = '{11'd1, 11'd1};    send_sequence();
        order = '{11'd3, 11'd2, 11'd1}; send_sequence();
        order = '{11'd0, 11'd1};    send_sequence();
        order = '{11'd2, 11'd3, 11'd1}; send_sequence();

        sent = 0;
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            case (ph)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 61; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 61; end
                default: begin idle_pct = 13; stall_pct = 13; end
            endcase
            if (ph == 0)
            begin
                // results back up behind a long receiver stall
                hold_req = 1'b1;
                repeat (20)
                    random_sequence(1'b1);
            end
            while (sent < (ph + 1) * RAND_ITEMS / NUM_PHASES)
                random_sequence(1'b0);
        end

        in_valid <= 1'b0;
        wait (pending == 0);
        repeat (50) @(negedge clk);
        if (errors == 0)
            $display("stack_pop_sequence_checker verification clean");
        else
            $display("stack_pop_sequence_checker verification failed");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("stack_pop_sequence_checker verification failed");
        $finish;
    end

endmodule
